[sv/tfl_pkg.sv]
// ---------------------------------------------------------------------------
// tfl_pkg: shared types and constants for the tilt FIR LED bar PWM block
// Field widths, register indexes, reset values and the bar pattern helper.
// ---------------------------------------------------------------------------
package tfl_pkg;

  localparam int TAPS_DEF        = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int GAIN_W    = 16;
  localparam int FRAC_BITS = 15;
  localparam int FILT_W    = 18;
  localparam int OFFS_W    = 10;
  localparam int PER_W     = 7;
  localparam int LVL_W     = 5;
  localparam int LED_W     = 8;
  localparam int SEL_W     = 3;
  localparam int ACC_W     = SEL_W + LVL_W + 1;

  localparam int FILT_MAX = 131071;
  localparam int FILT_MIN = -131072;

  // Configuration port
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int NUM_GAIN_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd5;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET [NUM_GAIN_REGS] =
    '{-16'sd3945, 16'sd9434, 16'sd20870, 16'sd9434};
  localparam logic signed [OFFS_W-1:0] OFFSET_RESET = -10'sd32;
  localparam logic [PER_W-1:0]         PERIOD_RESET = 7'd16;

  // Opcodes of an input beat
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [LED_W-1:0] BAR_SEED = 8'h08;

  typedef logic [LED_W-1:0] led_t;

  // Control handed to the bar / PWM stage
  typedef struct packed {
    logic fire;
    logic is_tick;
  } stage_ctl_t;

  // Seed rotated right within the bar by sel
  function automatic led_t bar_onehot(input logic [SEL_W-1:0] sel);
    logic [2*LED_W-1:0] dbl;
    dbl = {BAR_SEED, BAR_SEED} >> sel;
    return dbl[LED_W-1:0];
  endfunction

endpackage

[sv/tfl_tap_cell.sv]
// ---------------------------------------------------------------------------
// tfl_tap_cell: one cell of the FIR delay line
// Holds one sample, passes it to the next cell on a shift and registers
// the product of the incoming sample and its gain.
// ---------------------------------------------------------------------------
module tfl_tap_cell
  import tfl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift_en,
  input  logic signed [SAMPLE_BITS-1:0]        tap_in,
  input  logic signed [GAIN_W-1:0]             gain,
  output logic signed [SAMPLE_BITS-1:0]        tap_out,
  output logic signed [SAMPLE_BITS+GAIN_W-1:0] prod_out
);

  logic signed [SAMPLE_BITS-1:0]        tap_r;
  logic signed [SAMPLE_BITS+GAIN_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (shift_en) begin
      tap_r <= tap_in;
    end
  end

  // product follows the sample just shifted in
  always_ff @(posedge clk) begin
    if (shift_en) begin
      prod_r <= tap_in * gain;
    end
  end

  assign tap_out  = tap_r;
  assign prod_out = prod_r;

endmodule

[sv/tfl_bar_pwm.sv]
// ---------------------------------------------------------------------------
// tfl_bar_pwm: bar conversion and PWM dimming stage
// Holds the filtered value, bar pattern, level, PWM counter and LED drive.
// ---------------------------------------------------------------------------
module tfl_bar_pwm
  import tfl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  stage_ctl_t               ctl,
  input  logic signed [FILT_W-1:0] filt_in,
  input  logic signed [OFFS_W-1:0] zero_offset,
  input  logic [PER_W-1:0]         wrap_at,
  output led_t                     led_drive,
  output logic [LVL_W-1:0]         bright_level,
  output logic signed [FILT_W-1:0] filtered_value
);

  logic signed [FILT_W-1:0] filt_r;
  led_t                     bar_r;
  led_t                     led_r;
  logic [LVL_W-1:0]         level_r;
  logic [PER_W-1:0]         cnt_r;

  // only the low bits of filtered + offset reach the bar
  logic [ACC_W-1:0] acc_c;
  assign acc_c = filt_in[ACC_W-1:0] + zero_offset[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= '0;
      bar_r   <= '0;
      led_r   <= '0;
      level_r <= '0;
      cnt_r   <= '0;
    end else if (ctl.fire) begin
      if (ctl.is_tick) begin
        // dim: shifted pattern while the counter is below the level
        if (cnt_r < {{(PER_W-LVL_W){1'b0}}, level_r}) begin
          led_r <= bar_r >> 1;
        end else begin
          led_r <= bar_r;
        end
        if (cnt_r > wrap_at) begin
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else begin
        filt_r  <= filt_in;
        bar_r   <= bar_onehot(acc_c[ACC_W-1:LVL_W+1]);
        level_r <= acc_c[LVL_W:1];
      end
    end
  end

  assign led_drive      = led_r;
  assign bright_level   = level_r;
  assign filtered_value = filt_r;

endmodule

[sv/tilt_fir_led_bar_pwm.sv]
// ---------------------------------------------------------------------------
// tilt_fir_led_bar_pwm: tilt FIR filter driving a dimmed one-hot LED bar
// A row of tap cells filters tilt samples; the last stage turns the result
// into a bar pattern and level, and timer ticks run the PWM dimming.
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid in_ready in_opcode in_tilt_sample  | into block
//   out     | out_valid out_ready out_led_drive           | out of block
//           | out_bright_level out_filtered_value         |
//   cfg     | cfg_we cfg_index cfg_wdata                  | into block
//
// One beat per cycle in each direction while the output is not stalled;
// every beat taken gives one result beat: tap cells multiply, then sum,
// then scale and saturate, then the bar / PWM stage updates its state.
// The whole pipe advances whenever the output register is empty or taken,
// so a stalled output holds every stage and in_ready drops with it.
// Reset is synchronous and returns taps, state and gains to their defaults.
// ---------------------------------------------------------------------------
module tilt_fir_led_bar_pwm
  import tfl_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic signed [SAMPLE_BITS-1:0] in_tilt_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LED_W-1:0]             out_led_drive,
  output logic [LVL_W-1:0]             out_bright_level,
  output logic signed [FILT_W-1:0]     out_filtered_value,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int GN  = (TAPS < NUM_GAIN_REGS) ? TAPS : NUM_GAIN_REGS;
  localparam int PW  = SAMPLE_BITS + GAIN_W;
  localparam int SW  = PW + $clog2(TAPS);
  localparam int SWX = (SW > FRAC_BITS + FILT_W + 1) ? SW : FRAC_BITS + FILT_W + 1;

  localparam logic signed [SWX-1:0] QMAX = SWX'(FILT_MAX);
  localparam logic signed [SWX-1:0] QMIN = SWX'(FILT_MIN);
  localparam logic signed [SWX-1:0] RND  = SWX'((1 << FRAC_BITS) - 1);

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_r [GN];
  logic signed [OFFS_W-1:0] offset_r;
  logic [PER_W-1:0]         period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < GN; g++) begin
        gain_r[g] <= GAIN_RESET[g];
      end
      offset_r <= OFFSET_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      for (int g = 0; g < GN; g++) begin
        if (cfg_index == CFG_TAP0 + CFG_IDX_W'(g)) begin
          gain_r[g] <= cfg_wdata[GAIN_W-1:0];
        end
      end
      if (cfg_index == CFG_OFFSET) begin
        offset_r <= cfg_wdata[OFFS_W-1:0];
      end
      if (cfg_index == CFG_PERIOD) begin
        period_r <= cfg_wdata[PER_W-1:0];
      end
    end
  end

  // Pipe control
  logic adv;
  logic in_fire;
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic op1_r, op2_r, op3_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_fire  = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_opcode;
      op2_r <= op1_r;
      op3_r <= op2_r;
    end
  end

  // Row of tap cells
  logic signed [SAMPLE_BITS-1:0] tap  [TAPS];
  logic signed [PW-1:0]          prod [TAPS];
  logic                          shift_en;

  assign shift_en = in_fire && (in_opcode == OP_SAMPLE);

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] cell_in;
    logic signed [GAIN_W-1:0]      cell_gain;

    if (i == 0) begin : g_head
      assign cell_in = in_tilt_sample;
    end else begin : g_link
      assign cell_in = tap[i-1];
    end

    // taps beyond the gain registers carry zero gain
    if (i < GN) begin : g_gain
      assign cell_gain = gain_r[i];
    end else begin : g_nogain
      assign cell_gain = '0;
    end

    tfl_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .tap_in   (cell_in),
      .gain     (cell_gain),
      .tap_out  (tap[i]),
      .prod_out (prod[i])
    );
  end

  // Sum of products
  logic signed [SWX-1:0] sum_c;
  logic signed [SWX-1:0] sum_r;

  always_comb begin
    sum_c = '0;
    for (int t = 0; t < TAPS; t++) begin
      sum_c = sum_c + SWX'(prod[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_c;
    end
  end

  // Scale toward zero and saturate
  logic signed [SWX-1:0]    bias_c;
  logic signed [SWX-1:0]    q_c;
  logic signed [FILT_W-1:0] f_c;
  logic signed [FILT_W-1:0] f_r;

  always_comb begin
    bias_c = sum_r[SWX-1] ? sum_r + RND : sum_r;
    q_c    = bias_c >>> FRAC_BITS;
    if (q_c > QMAX) begin
      f_c = QMAX[FILT_W-1:0];
    end else if (q_c < QMIN) begin
      f_c = QMIN[FILT_W-1:0];
    end else begin
      f_c = q_c[FILT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r <= f_c;
    end
  end

  // Bar and PWM stage
  stage_ctl_t ctl;

  assign ctl.fire    = adv && v3_r;
  assign ctl.is_tick = (op3_r == OP_TICK);

  tfl_bar_pwm u_bar (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .filt_in        (f_r),
    .zero_offset    (offset_r),
    .wrap_at        (period_r),
    .led_drive      (out_led_drive),
    .bright_level   (out_bright_level),
    .filtered_value (out_filtered_value)
  );

  assign out_valid = out_valid_r;

endmodule

[sv/tfl_checker.sv]
// ---------------------------------------------------------------------------
// tfl_checker: port-level checks for tilt_fir_led_bar_pwm
// Watches the handshakes and the result fields over time.
// ---------------------------------------------------------------------------
module tfl_checker
  import tfl_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [LED_W-1:0]         out_led_drive,
  input logic [LVL_W-1:0]         out_bright_level,
  input logic signed [FILT_W-1:0] out_filtered_value
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // result fields move only when a new beat is presented
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> out_valid || ($stable(out_led_drive) &&
      $stable(out_bright_level) && $stable(out_filtered_value)))
    else $error("result fields changed without a beat");

  // empty output register never blocks the input
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // a taken result frees the pipe for a new input beat
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("in_ready low while result taken");

endmodule

bind tilt_fir_led_bar_pwm tfl_checker u_tfl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_led_drive      (out_led_drive),
  .out_bright_level   (out_bright_level),
  .out_filtered_value (out_filtered_value)
);
